@@ rtl/lg_pkg.sv @@
package lg_pkg;

    // fixed field widths
    localparam int LG_ROW_W = 64;
    localparam int LG_CNT_W = 7;

    // result queue sizing
    localparam int LG_FIFO_DEPTH = 4;
    localparam int LG_PTR_W      = $clog2(LG_FIFO_DEPTH);
    localparam int LG_OCC_W      = $clog2(LG_FIFO_DEPTH + 1);

    // input beat
    typedef struct packed {
        logic [LG_ROW_W-1:0] row_cells;
        logic                last_row;
    } lg_in_t;

    // result beat
    typedef struct packed {
        logic [LG_ROW_W-1:0] next_cells;
        logic                board_done;
    } lg_out_t;

    // bits one column hands to its neighbors
    typedef struct packed {
        logic upper;
        logic middle;
        logic row;
    } lg_col_t;

endpackage

@@ rtl/lg_cell.sv @@
module lg_cell
    import lg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  logic    clear,
    input  logic    live,
    input  logic    row_bit,
    input  lg_col_t left_nbr,
    input  lg_col_t right_nbr,
    output lg_col_t own,
    output logic    res_mid,
    output logic    res_new
);

    logic upper_reg;
    logic upper_next;
    logic middle_reg;
    logic middle_next;
    logic row_in;

    // b3/s23 rule on a 3x3 window, bit 1 of here is the cell itself
    function automatic logic life_rule(input logic [2:0] above,
                                       input logic [2:0] here,
                                       input logic [2:0] below);
        logic [3:0] n;
        n = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
          + 4'(here[0]) + 4'(here[2])
          + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
        return (n == 4'd3) || (here[1] && (n == 4'd2));
    endfunction

    // incoming bit, dead beyond the column limit
    assign row_in = row_bit & live;

    assign own.upper  = upper_reg;
    assign own.middle = middle_reg;
    assign own.row    = row_in;

    // pending row against the new row below it
    assign res_mid = live & life_rule({right_nbr.upper,  upper_reg,  left_nbr.upper},
                                      {right_nbr.middle, middle_reg, left_nbr.middle},
                                      {right_nbr.row,    row_in,     left_nbr.row});

    // new row as the bottom row, dead below
    assign res_new = live & life_rule({right_nbr.middle, middle_reg, left_nbr.middle},
                                      {right_nbr.row,    row_in,     left_nbr.row},
                                      3'b000);

    // row history update
    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (clear)
        begin
            upper_next  = 1'b0;
            middle_next = 1'b0;
        end
        else if (shift)
        begin
            upper_next  = middle_reg;
            middle_next = row_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
        end
    end

endmodule

@@ rtl/lg_out_fifo.sv @@
module lg_out_fifo
    import lg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic [1:0] push_cnt,
    input  lg_out_t push_data0,
    input  lg_out_t push_data1,
    output logic    no_room,
    output logic    out_valid,
    input  logic    out_stall,
    output lg_out_t out_data
);

    lg_out_t             entry_reg [LG_FIFO_DEPTH];
    logic [LG_PTR_W-1:0] wr_ptr_reg;
    logic [LG_PTR_W-1:0] wr_ptr_next;
    logic [LG_PTR_W-1:0] rd_ptr_reg;
    logic [LG_PTR_W-1:0] rd_ptr_next;
    logic [LG_OCC_W-1:0] count_reg;
    logic [LG_OCC_W-1:0] count_next;
    logic                pop;

    // head beat and room for a two-result beat
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid & ~out_stall;
    assign no_room   = (count_reg > LG_OCC_W'(LG_FIFO_DEPTH - 2));

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + LG_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + LG_PTR_W'(pop);
        count_next  = count_reg + LG_OCC_W'(push_cnt) - LG_OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + LG_PTR_W'(1)] <= push_data1;
        end
    end

endmodule

@@ rtl/life_generation_row_engine.sv @@
// One Game of Life generation (birth on 3, survival on 2 or 3) over a board
// whose outside is dead, streamed one row of up to 64 cells per input beat.
// A row of MAX_COLS column cells holds the two rows before the newest one;
// each cell trades its bits with its neighbors and applies the rule for its
// own column. A row's next state is queued when the row below it arrives, so
// the first row gives no result, each later row gives one, and a beat with
// last_row set then also gives the bottom row, with board_done, and leaves the
// block empty for the next board. An input beat is taken every cycle while
// in_stall is low; a four-entry result queue decouples the sides, and in_stall
// rises while fewer than two entries are free. With the output side always
// ready the queue never holds more than two results, whatever the board
// length, so only a stalled output side reduces the input rate. Columns at or
// beyond col_count (or MAX_COLS) are dead and read as 0. cfg_ready is always
// high; write col_count only while no results are pending.
module life_generation_row_engine
    import lg_pkg::*;
#(
    parameter int MAX_COLS = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  lg_in_t              in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output lg_out_t             out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [LG_CNT_W-1:0] cfg_data
);

    logic [LG_CNT_W-1:0] col_count_reg;
    logic                pending_reg;
    logic                pending_next;
    logic                accept;
    logic                last;
    logic                shift;
    logic                clear;
    logic                no_room;
    logic [1:0]          push_cnt;
    lg_out_t             push_data0;
    lg_out_t             push_data1;
    logic [LG_ROW_W-1:0] res_mid_bits;
    logic [LG_ROW_W-1:0] res_new_bits;
    lg_col_t             col_bits [MAX_COLS];

    // column limit register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= LG_CNT_W'(64);
        end
        else if (cfg_valid)
        begin
            col_count_reg <= cfg_data;
        end
    end

    // input handshake and row control
    assign in_stall = no_room;
    assign accept   = in_valid & ~no_room;
    assign last     = in_data.last_row;
    assign shift    = accept & ~last;
    assign clear    = accept & last;

    always_comb
    begin
        pending_next = pending_reg;
        if (accept)
        begin
            pending_next = ~last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // chain of column cells
    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col
        lg_col_t left_nbr;
        lg_col_t right_nbr;
        logic    live;

        if (c == 0)
        begin : g_left_edge
            assign left_nbr = '0;
        end
        else
        begin : g_left
            assign left_nbr = col_bits[c-1];
        end

        if (c == MAX_COLS - 1)
        begin : g_right_edge
            assign right_nbr = '0;
        end
        else
        begin : g_right
            assign right_nbr = col_bits[c+1];
        end

        assign live = (col_count_reg > LG_CNT_W'(c));

        lg_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (shift),
            .clear     (clear),
            .live      (live),
            .row_bit   (in_data.row_cells[c]),
            .left_nbr  (left_nbr),
            .right_nbr (right_nbr),
            .own       (col_bits[c]),
            .res_mid   (res_mid_bits[c]),
            .res_new   (res_new_bits[c])
        );
    end

    // columns past the cell row are dead
    for (genvar c = MAX_COLS; c < LG_ROW_W; c++)
    begin : g_dead
        assign res_mid_bits[c] = 1'b0;
        assign res_new_bits[c] = 1'b0;
    end

    // results queued by this beat
    always_comb
    begin
        push_cnt              = 2'd0;
        push_data0.next_cells = res_new_bits;
        push_data0.board_done = 1'b1;
        push_data1.next_cells = res_new_bits;
        push_data1.board_done = 1'b1;
        if (accept)
        begin
            if (pending_reg)
            begin
                push_data0.next_cells = res_mid_bits;
                push_data0.board_done = 1'b0;
                push_cnt              = last ? 2'd2 : 2'd1;
            end
            else
            begin
                push_cnt = last ? 2'd1 : 2'd0;
            end
        end
    end

    lg_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_data0 (push_data0),
        .push_data1 (push_data1),
        .no_room    (no_room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

@@ bench/testbench.sv @@
module testbench;
    import lg_pkg::*;

    // bench timing
    localparam int DRAIN_CYCLES = 12;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ROWS   = 65;
    localparam int DIR_STEPS    = 27;

    typedef enum logic {STEP_ROW, STEP_CFG} step_kind_t;

    // one line of the directed table
    typedef struct packed {
        step_kind_t          kind;
        logic [LG_ROW_W-1:0] cells;
        logic                last;
        logic [LG_CNT_W-1:0] cols;
        logic                typed;
        logic [LG_ROW_W-1:0] typed_next;
    } dir_step_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    lg_in_t              in_data;
    logic                out_valid;
    logic                out_stall;
    lg_out_t             out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LG_CNT_W-1:0] cfg_data;

    // predictor state
    logic [LG_ROW_W-1:0] prev_row;
    logic [LG_ROW_W-1:0] pend_row;
    logic [1:0]          rows_pending;
    logic [LG_CNT_W-1:0] cols_setting;

    // rows whose next state is still due at the output
    lg_out_t next_rows_due [$];

    dir_step_t dir_table [DIR_STEPS];

    int errors;
    int rows_sent;
    int boards_sent;
    int results_checked;
    int settings_done;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_req;
    int quiet_cycles;
    int phase;
    int rows_in_phase;
    int board_len;
    int r;
    int i;
    bit pressed;

    life_generation_row_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // live column mask for a column setting
    function automatic logic [LG_ROW_W-1:0] col_mask(input logic [LG_CNT_W-1:0] cols);
        int n;
        n = (cols > LG_ROW_W) ? LG_ROW_W : int'(cols);
        if (n >= LG_ROW_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // b3/s23 rule over one row with its neighbors
    function automatic logic [LG_ROW_W-1:0] life_next_row(
        input logic [LG_ROW_W-1:0] above,
        input logic [LG_ROW_W-1:0] here,
        input logic [LG_ROW_W-1:0] below,
        input logic [LG_CNT_W-1:0] cols
    );
        logic [LG_ROW_W-1:0] nxt;
        int n;
        int c;
        int d;
        nxt = '0;
        for (c = 0; c < LG_ROW_W; c++)
        begin
            n = 0;
            for (d = -1; d <= 1; d++)
            begin
                if (c + d >= 0 && c + d < LG_ROW_W)
                begin
                    n += int'(above[c+d]) + int'(below[c+d]);
                    if (d != 0)
                        n += int'(here[c+d]);
                end
            end
            if (n == 3 || (here[c] && n == 2))
                nxt[c] = 1'b1;
        end
        return nxt & col_mask(cols);
    endfunction

    // advance the predictor by one accepted row
    task automatic predict_row(input lg_in_t beat, output lg_out_t first,
                               output lg_out_t second, output int count);
        logic [LG_ROW_W-1:0] cells;
        cells  = beat.row_cells & col_mask(cols_setting);
        count  = 0;
        first  = '0;
        second = '0;
        if (rows_pending == 2'd0)
        begin
            if (beat.last_row)
            begin
                first = '{next_cells: life_next_row('0, cells, '0, cols_setting),
                          board_done: 1'b1};
                count = 1;
            end
            else
            begin
                prev_row     = '0;
                pend_row     = cells;
                rows_pending = 2'd1;
            end
        end
        else
        begin
            first = '{next_cells: life_next_row(prev_row, pend_row, cells, cols_setting),
                      board_done: 1'b0};
            count = 1;
            if (beat.last_row)
            begin
                second = '{next_cells: life_next_row(pend_row, cells, '0, cols_setting),
                           board_done: 1'b1};
                count        = 2;
                prev_row     = '0;
                pend_row     = '0;
                rows_pending = 2'd0;
            end
            else
            begin
                prev_row     = pend_row;
                pend_row     = cells;
                rows_pending = 2'd2;
            end
        end
    endtask

    // offer one row beat and book its results
    task automatic send_row(input lg_in_t beat, input logic typed,
                            input logic [LG_ROW_W-1:0] typed_next);
        lg_out_t r0;
        lg_out_t r1;
        int n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (in_stall);
        predict_row(beat, r0, r1, n);
        // a typed value replaces the bottom row's prediction
        if (typed && n == 2)
            r1.next_cells = typed_next;
        else if (typed && n == 1)
            r0.next_cells = typed_next;
        if (n >= 1)
            next_rows_due.push_back(r0);
        if (n == 2)
            next_rows_due.push_back(r1);
        rows_sent++;
        if (beat.last_row)
            boards_sent++;
    endtask

    // let every due result come out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (next_rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // column count register write
    task automatic write_cols(input logic [LG_CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cols_setting = value;
        settings_done++;
    endtask

    // random row with varied density and edge patterns
    function automatic logic [LG_ROW_W-1:0] random_cells();
        logic [LG_ROW_W-1:0] a;
        logic [LG_ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(7))
            0: return a & b;
            1: return a | b;
            2: return a & b & {$urandom, $urandom};
            3: return ($urandom_range(1) == 0) ? '0 : '1;
            4: return 64'h7 << $urandom_range(61);
            5: return {a[63:60], 56'd0, b[3:0]};
            default: return a;
        endcase
    endfunction

    // column setting of each random phase
    function automatic logic [LG_CNT_W-1:0] phase_cols(input int p);
        case (p)
            0: return 7'd64;
            1: return 7'd37;
            2: return 7'd2;
            3: return 7'd64;
            4: return 7'd127;
            default: return LG_CNT_W'($urandom_range(1, 64));
        endcase
    endfunction

    // result side: stall pattern, long hold-off and checking
    initial
    begin : result_side
        int hold_left;
        bit hold_taken;
        lg_out_t want;
        hold_left  = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (next_rows_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, next_cells %h board_done %b",
                             $time, out_data.next_cells, out_data.board_done);
                    errors++;
                end
                else
                begin
                    want = next_rows_due.pop_front();
                    if (want.next_cells !== out_data.next_cells)
                    begin
                        $display("%0t: next_cells mismatch, expected %h actual %h",
                                 $time, want.next_cells, out_data.next_cells);
                        errors++;
                    end
                    if (want.board_done !== out_data.board_done)
                    begin
                        $display("%0t: board_done mismatch, expected %b actual %b",
                                 $time, want.board_done, out_data.board_done);
                        errors++;
                    end
                    results_checked++;
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
            if (hold_left > 0)
                hold_left--;
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("life_generation_row_engine regression: fail");
            $finish;
        end
    end

    // directed table
    initial
    begin
        dir_table[0]  = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE};
        dir_table[1]  = '{STEP_ROW, '0, 1'b1, 7'd0, 1'b1, 64'h0};
        // blinker in a three-row board
        dir_table[2]  = '{STEP_ROW, '0, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[3]  = '{STEP_ROW, 64'h1C, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[4]  = '{STEP_ROW, '0, 1'b1, 7'd0, 1'b1, 64'h08};
        // full two-row board, only the corners live
        dir_table[5]  = '{STEP_ROW, '1, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[6]  = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b1, 64'h8000_0000_0000_0001};
        dir_table[7]  = '{STEP_ROW, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 7'd0, 1'b1, 64'h0};
        // clusters on both edge columns
        dir_table[8]  = '{STEP_ROW, 64'hC000_0000_0000_0003, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[9]  = '{STEP_ROW, 64'h8000_0000_0000_0001, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[10] = '{STEP_ROW, 64'hC000_0000_0000_0003, 1'b1, 7'd0, 1'b0, 64'h0};
        // narrow, empty and oversized column settings
        dir_table[11] = '{STEP_CFG, '0, 1'b0, 7'd1, 1'b0, 64'h0};
        dir_table[12] = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b1, 64'h0};
        dir_table[13] = '{STEP_CFG, '0, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[14] = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b1, 64'h0};
        dir_table[15] = '{STEP_CFG, '0, 1'b0, 7'd127, 1'b0, 64'h0};
        dir_table[16] = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE};
        dir_table[17] = '{STEP_CFG, '0, 1'b0, 7'd3, 1'b0, 64'h0};
        dir_table[18] = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b1, 64'h2};
        // column count changed in the middle of a board
        dir_table[19] = '{STEP_CFG, '0, 1'b0, 7'd64, 1'b0, 64'h0};
        dir_table[20] = '{STEP_ROW, '1, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[21] = '{STEP_CFG, '0, 1'b0, 7'd8, 1'b0, 64'h0};
        dir_table[22] = '{STEP_ROW, '1, 1'b1, 7'd0, 1'b0, 64'h0};
        dir_table[23] = '{STEP_CFG, '0, 1'b0, 7'd65, 1'b0, 64'h0};
        dir_table[24] = '{STEP_ROW, 64'h5555_5555_5555_5555, 1'b0, 7'd0, 1'b0, 64'h0};
        dir_table[25] = '{STEP_ROW, 64'h3333_3333_3333_3333, 1'b1, 7'd0, 1'b0, 64'h0};
        dir_table[26] = '{STEP_CFG, '0, 1'b0, 7'd64, 1'b0, 64'h0};
    end

    // reset, directed table, random phases, final verdict
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_req      = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        prev_row      = '0;
        pend_row      = '0;
        rows_pending  = 2'd0;
        cols_setting  = 7'd64;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_STEPS; i++)
        begin
            if (dir_table[i].kind == STEP_CFG)
            begin
                wait_idle();
                write_cols(dir_table[i].cols);
            end
            else
            begin
                send_row('{row_cells: dir_table[i].cells, last_row: dir_table[i].last},
                         dir_table[i].typed, dir_table[i].typed_next);
            end
        end

        for (phase = 0; phase < 6; phase++)
        begin
            wait_idle();
            write_cols(phase_cols(phase));
            // sender light / receiver heavy, then swapped, then none
            if (phase < 2)
            begin
                send_idle_pct = 6;
                recv_idle_pct = 45;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 6;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            rows_in_phase = 0;
            pressed       = 1'b0;
            while (rows_in_phase < PHASE_ROWS)
            begin
                case ($urandom_range(9))
                    0, 1: board_len = 1;
                    2:    board_len = 2;
                    default: board_len = $urandom_range(3, 10);
                endcase
                for (r = 0; r < board_len; r++)
                begin
                    send_row('{row_cells: random_cells(), last_row: (r == board_len - 1)},
                             1'b0, '0);
                    rows_in_phase++;
                    // long result hold-off while rows keep coming
                    if (phase == 0 && !pressed && rows_in_phase >= 20)
                    begin
                        hold_req = 1'b1;
                        pressed  = 1'b1;
                    end
                end
            end
        end

        wait_idle();
        $display("rows sent %0d in %0d boards, results checked %0d, column settings %0d",
                 rows_sent, boards_sent, results_checked, settings_done);
        $display("covered edge columns, single and two row boards, mid-board column change");
        if (errors == 0)
            $display("life_generation_row_engine regression: pass");
        else
            $display("life_generation_row_engine regression: fail");
        $finish;
    end

endmodule
